// ===== design/frustum_cull_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// frustum_cull_classifier_defines
// assertion macros shared by the frustum cull classifier
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_CLASSIFIER_DEFINES_SVH
`define FRUSTUM_CULL_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define FCC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// shared types and constants of the frustum cull classifier
// ----------------------------------------------------------------------------
`default_nettype none

package fcc_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int FRAC_BITS   = 14;
  localparam int COEF_W      = 16;
  localparam int PLANE_W     = 4 * COEF_W;
  localparam int CFG_INDEX_W = 3;
  // d and the radius are scaled by 2^14, and once more by two for doubled coords
  localparam int D_SHIFT     = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    OP_BOX    = 2'd0,
    OP_SPHERE = 2'd1,
    OP_POINT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    LOC_OUTSIDE   = 2'd0,
    LOC_INTERSECT = 2'd1,
    LOC_INSIDE    = 2'd2
  } location_t;

  // d in the top bits, a in the bottom bits
  typedef struct packed {
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] a;
  } plane_t;

  typedef struct packed {
    logic mul;
    logic add;
    logic cmp;
  } stage_en_t;

  typedef struct packed {
    logic outside;
    logic straddle;
  } verdict_t;

endpackage

`default_nettype wire

// ===== design/frustum_cull_classifier.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_classifier
// classifies a box, sphere or point against six frustum planes
// ----------------------------------------------------------------------------
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   first_x/y/z, second_x/y/z, radius       operation
//   m_axis    out  location (0 out, 1 straddle, 2 inside)  -
//   cfg       in   plane_0..plane_5 by index, 64 bits      -
//
// one beat per cycle sustained while the output is not stalled; a result passes
// through prep, multiply, add, compare and the output register
// every stage holds its own valid bit, so a stalled output only blocks the
// input once all five stages are full
// synchronous reset clears the valid bits and all planes to zero
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_classifier #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, radius
  input  wire logic [((7*COORD_WIDTH-1+7)/8)*8-1:0]  s_axis_tdata,
  // operation
  input  wire logic [1:0]                            s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // location
  output logic [7:0]                                 m_axis_tdata,
  input  wire logic                                  cfg_we,
  input  wire logic [fcc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [fcc_pkg::PLANE_W-1:0]           cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int RW = CW - 1 + fcc_pkg::D_SHIFT;

  fcc_pkg::plane_t [fcc_pkg::NUM_PLANES-1:0] planes;
  fcc_pkg::verdict_t                         verdicts [fcc_pkg::NUM_PLANES];
  fcc_pkg::stage_en_t                        en;

  logic signed [CW-1:0] first_x, first_y, first_z, second_x, second_y, second_z;
  logic [CW-2:0]        radius;
  logic signed [CW:0]   cx, cy, cz, hx, hy, hz;
  logic [RW-1:0]        rad_term, rad_m;
  logic                 sph_p, sph_m, sph_a;

  logic p_v, m_v, a_v, c_v, o_v;
  logic rdy_p, rdy_m, rdy_a, rdy_c, rdy_o;
  logic [fcc_pkg::NUM_PLANES-1:0] outside_vec, strad_vec;
  fcc_pkg::location_t location, location_next;

  assign first_x  = s_axis_tdata[0*CW +: CW];
  assign first_y  = s_axis_tdata[1*CW +: CW];
  assign first_z  = s_axis_tdata[2*CW +: CW];
  assign second_x = s_axis_tdata[3*CW +: CW];
  assign second_y = s_axis_tdata[4*CW +: CW];
  assign second_z = s_axis_tdata[5*CW +: CW];
  assign radius   = s_axis_tdata[6*CW +: CW-1];

  // a stage may load when it is empty or the stage after it loads
  assign rdy_o = ~o_v | m_axis_tready;
  assign rdy_c = ~c_v | rdy_o;
  assign rdy_a = ~a_v | rdy_c;
  assign rdy_m = ~m_v | rdy_a;
  assign rdy_p = ~p_v | rdy_m;
  assign s_axis_tready = rdy_p;

  assign en.mul = rdy_m;
  assign en.add = rdy_a;
  assign en.cmp = rdy_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      m_v <= 1'b0;
      a_v <= 1'b0;
      c_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (rdy_p) p_v <= s_axis_tvalid;
      if (rdy_m) m_v <= p_v;
      if (rdy_a) a_v <= m_v;
      if (rdy_c) c_v <= a_v;
      if (rdy_o) o_v <= c_v;
    end
  end

  // sphere flag and radius ride alongside the per-plane pipelines
  always_ff @(posedge clk) begin
    if (rdy_m) begin
      sph_m <= sph_p;
      rad_m <= rad_term;
    end
    if (rdy_a) begin
      sph_a <= sph_m;
    end
  end

  fcc_plane_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  fcc_prep #(
    .CW (CW)
  ) u_prep (
    .clk       (clk),
    .en        (rdy_p),
    .operation (s_axis_tuser),
    .first_x   (first_x),
    .first_y   (first_y),
    .first_z   (first_z),
    .second_x  (second_x),
    .second_y  (second_y),
    .second_z  (second_z),
    .radius    (radius),
    .cx        (cx),
    .cy        (cy),
    .cz        (cz),
    .hx        (hx),
    .hy        (hy),
    .hz        (hz),
    .rad_term  (rad_term),
    .sph       (sph_p)
  );

  for (genvar g = 0; g < fcc_pkg::NUM_PLANES; g++) begin : g_plane
    fcc_plane_eval #(
      .CW (CW)
    ) u_eval (
      .clk      (clk),
      .en       (en),
      .plane    (planes[g]),
      .cx       (cx),
      .cy       (cy),
      .cz       (cz),
      .hx       (hx),
      .hy       (hy),
      .hz       (hz),
      .rad_term (rad_m),
      .sph      (sph_a),
      .verdict  (verdicts[g])
    );
    assign outside_vec[g] = verdicts[g].outside;
    assign strad_vec[g]   = verdicts[g].straddle;
  end

  always_comb begin
    if (|outside_vec) begin
      location_next = fcc_pkg::LOC_OUTSIDE;
    end else if (|strad_vec) begin
      location_next = fcc_pkg::LOC_INTERSECT;
    end else begin
      location_next = fcc_pkg::LOC_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      location <= location_next;
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = {6'b0, location};

  `include "frustum_cull_classifier_defines.svh"

  `FCC_ASSERT_IMPL(a_blocked_only_when_full, !s_axis_tready, p_v && m_v && a_v && c_v && o_v, "input blocked with a bubble in the pipeline")
  `FCC_ASSERT_NEXT(a_accept_fills_prep, s_axis_tvalid && s_axis_tready, p_v, "accepted beat did not reach the prep stage")
  `FCC_ASSERT_NEXT(a_cmp_holds_on_stall, c_v && !rdy_o, c_v && $stable(outside_vec) && $stable(strad_vec), "compare stage changed while stalled")

endmodule

`default_nettype wire

// ===== design/fcc_plane_regs.sv =====
// ----------------------------------------------------------------------------
// fcc_plane_regs
// the six plane coefficient registers behind the write port
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_plane_regs (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        cfg_we,
  input  wire logic [fcc_pkg::CFG_INDEX_W-1:0]             cfg_index,
  input  wire logic [fcc_pkg::PLANE_W-1:0]                 cfg_data,
  output fcc_pkg::plane_t [fcc_pkg::NUM_PLANES-1:0]        planes
);

  logic [fcc_pkg::PLANE_W-1:0] plane_q [fcc_pkg::NUM_PLANES];

  // indexes past the last plane match nothing and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fcc_pkg::NUM_PLANES; i++) begin
        plane_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < fcc_pkg::NUM_PLANES; i++) begin
        if (cfg_we && (cfg_index == fcc_pkg::CFG_INDEX_W'(i))) begin
          plane_q[i] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < fcc_pkg::NUM_PLANES; i++) begin
      planes[i] = fcc_pkg::plane_t'(plane_q[i]);
    end
  end

endmodule

`default_nettype wire

// ===== design/fcc_prep.sv =====
// ----------------------------------------------------------------------------
// fcc_prep
// input stage: doubled center, doubled half extent and scaled radius
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_prep #(
  parameter int CW = 16
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [1:0]                         operation,
  input  wire logic signed [CW-1:0]               first_x,
  input  wire logic signed [CW-1:0]               first_y,
  input  wire logic signed [CW-1:0]               first_z,
  input  wire logic signed [CW-1:0]               second_x,
  input  wire logic signed [CW-1:0]               second_y,
  input  wire logic signed [CW-1:0]               second_z,
  input  wire logic [CW-2:0]                      radius,
  output logic signed [CW:0]                      cx,
  output logic signed [CW:0]                      cy,
  output logic signed [CW:0]                      cz,
  output logic signed [CW:0]                      hx,
  output logic signed [CW:0]                      hy,
  output logic signed [CW:0]                      hz,
  output logic [CW-2+fcc_pkg::D_SHIFT:0]          rad_term,
  output logic                                    sph
);

  localparam int RW = CW - 1 + fcc_pkg::D_SHIFT;

  logic signed [CW:0] cx_next, cy_next, cz_next;
  logic signed [CW:0] hx_next, hy_next, hz_next;
  logic [RW-1:0]      rad_term_next;
  logic               sph_next;

  // sphere and point work on 2*center so all kinds share the box scaling
  always_comb begin
    cx_next       = {first_x, 1'b0};
    cy_next       = {first_y, 1'b0};
    cz_next       = {first_z, 1'b0};
    hx_next       = '0;
    hy_next       = '0;
    hz_next       = '0;
    rad_term_next = '0;
    sph_next      = 1'b0;
    case (fcc_pkg::op_t'(operation))
      fcc_pkg::OP_BOX: begin
        cx_next = (CW+1)'(first_x) + (CW+1)'(second_x);
        cy_next = (CW+1)'(first_y) + (CW+1)'(second_y);
        cz_next = (CW+1)'(first_z) + (CW+1)'(second_z);
        hx_next = (CW+1)'(second_x) - (CW+1)'(first_x);
        hy_next = (CW+1)'(second_y) - (CW+1)'(first_y);
        hz_next = (CW+1)'(second_z) - (CW+1)'(first_z);
      end
      fcc_pkg::OP_SPHERE: begin
        rad_term_next = {radius, {fcc_pkg::D_SHIFT{1'b0}}};
        sph_next      = 1'b1;
      end
      default: begin
        // point, and the unused code that also has bit 1 set
        sph_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx       <= cx_next;
      cy       <= cy_next;
      cz       <= cz_next;
      hx       <= hx_next;
      hy       <= hy_next;
      hz       <= hz_next;
      rad_term <= rad_term_next;
      sph      <= sph_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/fcc_plane_eval.sv =====
// ----------------------------------------------------------------------------
// fcc_plane_eval
// one plane: products, distance and extent sums, then the sign tests
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_plane_eval #(
  parameter int CW = 16
) (
  input  wire logic                               clk,
  input  wire fcc_pkg::stage_en_t                 en,
  input  wire fcc_pkg::plane_t                    plane,
  input  wire logic signed [CW:0]                 cx,
  input  wire logic signed [CW:0]                 cy,
  input  wire logic signed [CW:0]                 cz,
  input  wire logic signed [CW:0]                 hx,
  input  wire logic signed [CW:0]                 hy,
  input  wire logic signed [CW:0]                 hz,
  input  wire logic [CW-2+fcc_pkg::D_SHIFT:0]     rad_term,
  input  wire logic                               sph,
  output fcc_pkg::verdict_t                       verdict
);

  localparam int PW = CW + 18;
  localparam int SW = ((PW + 2 > 32) ? PW + 2 : 32) + 2;

  logic signed [fcc_pkg::COEF_W:0] abs_a, abs_b, abs_c;
  logic signed [PW-1:0] pa_next, pb_next, pc_next, qa_next, qb_next, qc_next;
  logic signed [PW-1:0] pa, pb, pc, qa, qb, qc;
  logic signed [SW-1:0] pa_x, pb_x, pc_x, qa_x, qb_x, qc_x, d_x, rad_x;
  logic signed [SW-1:0] s_next, t_next, s_sum, t_sum;
  logic signed [SW-1:0] plus, minus;
  fcc_pkg::verdict_t    verdict_next;

  // multiply stage
  always_comb begin
    abs_a   = plane.a[fcc_pkg::COEF_W-1] ? -(fcc_pkg::COEF_W+1)'(plane.a)
                                         : (fcc_pkg::COEF_W+1)'(plane.a);
    abs_b   = plane.b[fcc_pkg::COEF_W-1] ? -(fcc_pkg::COEF_W+1)'(plane.b)
                                         : (fcc_pkg::COEF_W+1)'(plane.b);
    abs_c   = plane.c[fcc_pkg::COEF_W-1] ? -(fcc_pkg::COEF_W+1)'(plane.c)
                                         : (fcc_pkg::COEF_W+1)'(plane.c);
    pa_next = PW'(plane.a) * PW'(cx);
    pb_next = PW'(plane.b) * PW'(cy);
    pc_next = PW'(plane.c) * PW'(cz);
    qa_next = PW'(abs_a) * PW'(hx);
    qb_next = PW'(abs_b) * PW'(hy);
    qc_next = PW'(abs_c) * PW'(hz);
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      pa <= pa_next;
      pb <= pb_next;
      pc <= pc_next;
      qa <= qa_next;
      qb <= qb_next;
      qc <= qc_next;
    end
  end

  // add stage: S is twice the scaled distance, T the scaled extent or radius
  assign pa_x  = SW'(pa);
  assign pb_x  = SW'(pb);
  assign pc_x  = SW'(pc);
  assign qa_x  = SW'(qa);
  assign qb_x  = SW'(qb);
  assign qc_x  = SW'(qc);
  assign d_x   = SW'(plane.d) <<< fcc_pkg::D_SHIFT;
  assign rad_x = SW'(rad_term);

  assign s_next = pa_x + pb_x + pc_x + d_x;
  assign t_next = qa_x + qb_x + qc_x + rad_x;

  always_ff @(posedge clk) begin
    if (en.add) begin
      s_sum <= s_next;
      t_sum <= t_next;
    end
  end

  // compare stage: a sphere touching the plane counts as outside / straddling
  always_comb begin
    plus                  = s_sum + t_sum;
    minus                 = s_sum - t_sum;
    verdict_next.outside  = plus[SW-1] | (sph & (plus == '0));
    verdict_next.straddle = minus[SW-1] | (sph & (minus == '0));
  end

  always_ff @(posedge clk) begin
    if (en.cmp) begin
      verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the frustum cull classifier against a bit-exact location predictor
// over directed corner queries and random box, sphere and point streams,
// under several plane sets, with random stalls on both stream sides
// ----------------------------------------------------------------------------

module testbench;
  import fcc_pkg::*;

  localparam int     CW            = 16;
  localparam int     TDATA_W       = ((7*CW-1+7)/8)*8;
  localparam longint ONE_Q         = longint'(1) << FRAC_BITS;
  localparam int     NUM_REGS      = 1 << CFG_INDEX_W;
  localparam int     SEGMENT_ITEMS = 305;
  localparam int     HOLD_CYCLES   = 100;
  localparam int     DRAIN_GAP     = 10;
  localparam int     WATCHDOG      = 4000;
  localparam int     REPORT_MAX    = 10;
  // code three also selects the point test
  localparam logic [1:0] OP_POINT_ALIAS = 2'd3;

  typedef enum int {SET_CUBE, SET_TILTED, SET_EXTREME, SET_RANDOM} plane_set_t;

  class location_scoreboard;
    plane_t      planes [NUM_PLANES];
    location_t   expected_q [$];
    int unsigned fail_count;

    function new();
      foreach (planes[i]) planes[i] = '0;
      fail_count = 0;
    endfunction

    function void set_plane(int idx, logic [PLANE_W-1:0] value);
      if (idx < NUM_PLANES) planes[idx] = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function location_t classify(logic [1:0] kind, logic [TDATA_W-1:0] data);
      longint fx, fy, fz, sx, sy, sz, rad;
      longint pa, pb, pc, pd, distance, s, t;
      int above, straddle;
      bit out_any;
      fx = longint'($signed(data[0*CW +: CW]));
      fy = longint'($signed(data[1*CW +: CW]));
      fz = longint'($signed(data[2*CW +: CW]));
      sx = longint'($signed(data[3*CW +: CW]));
      sy = longint'($signed(data[4*CW +: CW]));
      sz = longint'($signed(data[5*CW +: CW]));
      rad = longint'(data[6*CW +: CW-1]) * ONE_Q;
      above = 0;
      straddle = 0;
      out_any = 1'b0;
      for (int i = 0; i < NUM_PLANES; i++) begin
        pa = longint'(planes[i].a);
        pb = longint'(planes[i].b);
        pc = longint'(planes[i].c);
        pd = longint'(planes[i].d);
        if (kind[1]) begin
          if (pa*fx + pb*fy + pc*fz + pd*ONE_Q < 0) out_any = 1'b1;
        end else if (kind == OP_SPHERE) begin
          distance = pa*fx + pb*fy + pc*fz + pd*ONE_Q;
          if (distance <= -rad) out_any = 1'b1;
          if (distance > rad) above++;
        end else begin
          // doubled center and doubled half extent keep the box test exact
          s = pa*(fx+sx) + pb*(fy+sy) + pc*(fz+sz) + 2*pd*ONE_Q;
          t = (sx-fx)*mag(pa) + (sy-fy)*mag(pb) + (sz-fz)*mag(pc);
          if (s + t < 0) out_any = 1'b1;
          if (s - t < 0) straddle++;
        end
      end
      if (out_any) return LOC_OUTSIDE;
      if (kind[1]) return LOC_INSIDE;
      if (kind == OP_SPHERE) return (above == NUM_PLANES) ? LOC_INSIDE : LOC_INTERSECT;
      return (straddle == 0) ? LOC_INSIDE : LOC_INTERSECT;
    endfunction

    function void note_input(logic [1:0] kind, logic [TDATA_W-1:0] data);
      expected_q.push_back(classify(kind, data));
    endfunction

    function void check_result(logic [7:0] beat);
      location_t want;
      if (expected_q.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("unexpected result beat: got %0d", beat);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (beat !== {6'b0, want}) begin
          if (fail_count < REPORT_MAX)
            $display("location mismatch: expected %0d got %0d", want, beat);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [PLANE_W-1:0]     cfg_data = '0;

  location_scoreboard sb;
  int send_idle_pct = 10;
  int recv_idle_pct = 87;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  frustum_cull_classifier #(.COORD_WIDTH(CW)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [PLANE_W-1:0] make_plane(int a, int b, int c, int d);
    return {16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  function automatic logic [15:0] rand_coord(int span);
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2*span) - span);
  endfunction

  task automatic send_query(input logic [1:0] kind, input int fx, input int fy, input int fz,
                            input int sx, input int sy, input int sz, input int radius);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, 15'(radius), 16'(sz), 16'(sy), 16'(sx),
                      16'(fz), 16'(fy), 16'(fx)};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(input int span);
    int pick, hi;
    logic [1:0] kind;
    logic [15:0] f [3];
    logic [15:0] s [3];
    logic [14:0] rad;
    pick = $urandom_range(0, 19);
    kind = (pick < 8) ? OP_BOX : (pick < 14) ? OP_SPHERE : (pick < 19) ? OP_POINT
                                                                        : OP_POINT_ALIAS;
    for (int k = 0; k < 3; k++) begin
      f[k] = rand_coord(span);
      s[k] = 16'($urandom);
    end
    rad = 15'($urandom);
    // mostly well-formed boxes, the rest unordered corners
    if (kind == OP_BOX && $urandom_range(0, 3) != 0) begin
      for (int k = 0; k < 3; k++) begin
        hi = int'($signed(f[k])) + int'($urandom_range(0, span));
        s[k] = (hi > 32767) ? 16'h7fff : 16'(hi);
      end
    end
    if (kind == OP_SPHERE && $urandom_range(0, 4) != 0)
      rad = 15'($urandom_range(0, span));
    send_query(kind, f[0], f[1], f[2], s[0], s[1], s[2], rad);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // writes all register indexes; the two past the planes must be ignored
  task automatic apply_plane_set(input plane_set_t kind, input int size);
    logic [PLANE_W-1:0] regs [NUM_REGS];
    logic [15:0] ends [3];
    ends = '{16'h8000, 16'h7fff, 16'h0000};
    for (int i = 0; i < NUM_REGS; i++) regs[i] = {$urandom, $urandom};
    case (kind)
      SET_CUBE: begin
        regs[0] = make_plane(0, 0, 16384, size);
        regs[1] = make_plane(0, 0, -16384, size);
        regs[2] = make_plane(0, -16384, 0, size);
        regs[3] = make_plane(0, 16384, 0, size);
        regs[4] = make_plane(16384, 0, 0, size);
        regs[5] = make_plane(-16384, 0, 0, size);
      end
      SET_TILTED: begin
        // origin stays inside every plane
        for (int i = 0; i < NUM_PLANES; i++)
          regs[i] = make_plane(int'($urandom_range(0, 32768)) - 16384,
                               int'($urandom_range(0, 32768)) - 16384,
                               int'($urandom_range(0, 32768)) - 16384,
                               int'($urandom_range(500, size)));
      end
      SET_EXTREME: begin
        for (int i = 0; i < NUM_PLANES; i++)
          regs[i] = {ends[$urandom_range(0, 1)], ends[$urandom_range(0, 2)],
                     ends[$urandom_range(0, 2)], ends[$urandom_range(0, 2)]};
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= regs[i];
      sb.set_plane(i, regs[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_segment(input plane_set_t kind, input int size, input int span,
                             input int send_pct, input int recv_pct, input bit squeeze);
    drain_results();
    apply_plane_set(kind, size);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (squeeze) hold_reqs++;
    repeat (SEGMENT_ITEMS) send_random(span);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // planes still at reset: every distance is zero
    send_query(OP_BOX, 5, -7, 9, 100, 200, 300, 0);
    send_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0);
    send_query(OP_SPHERE, 10, 20, 30, 0, 0, 0, 5);
    send_query(OP_POINT, -32768, 32767, 0, 0, 0, 0, 32767);
    send_query(OP_POINT_ALIAS, 1, 2, 3, 0, 0, 0, 0);

    // axis aligned cube of half size 1000
    drain_results();
    apply_plane_set(SET_CUBE, 1000);
    send_query(OP_POINT, 0, 0, 0, 0, 0, 0, 0);
    send_query(OP_POINT, 1000, 0, 0, 0, 0, 0, 0);
    send_query(OP_POINT, 1001, 0, 0, 0, 0, 0, 0);
    send_query(OP_POINT, -32768, -32768, -32768, 0, 0, 0, 0);
    send_query(OP_POINT, 32767, 32767, 32767, -1, -1, -1, 32767);
    send_query(OP_POINT_ALIAS, 0, 0, 0, 0, 0, 0, 0);
    send_query(OP_POINT_ALIAS, 2000, 0, 0, 0, 0, 0, 0);
    send_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0);
    send_query(OP_SPHERE, 1000, 0, 0, 0, 0, 0, 0);
    send_query(OP_SPHERE, 1005, 0, 0, 0, 0, 0, 10);
    send_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, 32767);
    send_query(OP_SPHERE, 1020, 0, 0, 0, 0, 0, 20);
    send_query(OP_SPHERE, 980, 0, 0, 0, 0, 0, 20);
    send_query(OP_BOX, -100, -100, -100, 100, 100, 100, 0);
    send_query(OP_BOX, 900, 0, 0, 1100, 10, 10, 0);
    send_query(OP_BOX, 1001, 0, 0, 1200, 10, 10, 0);
    send_query(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    // maximum below minimum: half extent goes negative
    send_query(OP_BOX, 100, 100, 100, -100, -100, -100, 0);
    send_query(OP_BOX, 1100, 0, 0, 900, 0, 0, 0);
    send_query(OP_BOX, 0, 0, 0, 1000, 1000, 1000, 0);

    run_segment(SET_CUBE, 1500, 3000, 10, 87, 1'b0);
    run_segment(SET_TILTED, 8000, 10000, 10, 87, 1'b0);
    run_segment(SET_EXTREME, 0, 32767, 87, 10, 1'b0);
    run_segment(SET_RANDOM, 0, 32767, 87, 10, 1'b0);
    run_segment(SET_TILTED, 3000, 4000, 0, 0, 1'b1);
    run_segment(SET_CUBE, 20000, 32767, 0, 0, 1'b0);

    drain_results();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
